// File: rtl/update_sequence_controller_core_assert.svh
// Assertion macros for the update sequence controller checker.
`ifndef UPDATE_SEQUENCE_CONTROLLER_CORE_ASSERT_SVH
`define UPDATE_SEQUENCE_CONTROLLER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while rst is high.
`define USC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("update sequence controller: same-cycle check failed");

// Next-cycle implication, disabled while rst is high.
`define USC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("update sequence controller: next-cycle check failed");

`endif

// File: rtl/usc_pkg.sv
// Types and constants of the update sequence controller.
package usc_pkg;

   // Event codes carried in the command field.
   localparam logic [3:0] CMD_BEGIN    = 4'd0;
   localparam logic [3:0] CMD_DOWNLOAD = 4'd1;
   localparam logic [3:0] CMD_PROMOTE  = 4'd8;
   localparam logic [3:0] CMD_RESET    = 4'd9;

   // Update stages; a completion event code equals the stage it completes.
   typedef enum logic [3:0] {
      STAGE_IDLE         = 4'd0,
      STAGE_DOWNLOAD     = 4'd1,
      STAGE_VERIFY       = 4'd2,
      STAGE_MAIN_INSTALL = 4'd3,
      STAGE_MAIN_TEST    = 4'd4,
      STAGE_ZERO_XFER    = 4'd5,
      STAGE_ZERO_INSTALL = 4'd6,
      STAGE_ZERO_TEST    = 4'd7,
      STAGE_PROMOTE      = 4'd8,
      STAGE_COMPLETE     = 4'd9,
      STAGE_FAILED       = 4'd10
   } stage_type;

   // Recovery action recorded on a failure.
   typedef enum logic [1:0] {
      ACTION_NONE          = 2'd0,
      ACTION_KEEP          = 2'd1,
      ACTION_ROLLBACK_MAIN = 2'd2,
      ACTION_ROLLBACK_ZERO = 2'd3
   } action_type;

   // One input event, laid out as the low bits of the input tdata.
   typedef struct packed {
      logic       zero_image_changed;
      logic       success;
      logic [3:0] command;
   } usc_event_type;

   // Sequencer state.
   typedef struct packed {
      logic       zero_changed;
      action_type failure_action;
      stage_type  stage;
   } usc_state_type;

   localparam usc_state_type USC_STATE_RESET = '{
      zero_changed:   1'b0,
      failure_action: ACTION_NONE,
      stage:          STAGE_IDLE
   };

   // Outcome of one event: the state after it and whether it was taken.
   typedef struct packed {
      usc_state_type next;
      logic          accepted;
   } usc_step_type;

   // One result, laid out as the output tdata.
   typedef struct packed {
      logic       zero_flag;
      action_type failure_action;
      stage_type  stage;
      logic       accepted;
   } usc_result_type;

endpackage

// File: rtl/usc_input_stage.sv
// Input register that holds one event transaction until the next stage takes it.
module usc_input_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,
   input  logic                   advance,
   output logic                   item_valid,
   output usc_pkg::usc_event_type item
);
   import usc_pkg::*;

   logic          valid_ff;
   logic          valid_in;
   usc_event_type item_ff;
   logic          load;

   // The register is free when empty or when its item moves on this cycle.
   assign req_tready = !valid_ff || advance;
   assign load       = req_tvalid && req_tready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload capture; unused upper tdata bits are dropped.
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= usc_event_type'(req_tdata[5:0]);
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// File: rtl/usc_step.sv
// Next-state decision of the sequencer for one event.
module usc_step (
   input  usc_pkg::usc_state_type cur,
   input  usc_pkg::usc_event_type evt,
   output usc_pkg::usc_step_type  step
);
   import usc_pkg::*;

   action_type fail_action;

   // Failure action for the current stage: rollback of main or zero image, or keep.
   always_comb begin
      if (cur.stage == STAGE_MAIN_TEST) begin
         fail_action = ACTION_ROLLBACK_MAIN;
      end else if (cur.stage inside {STAGE_ZERO_XFER, STAGE_ZERO_INSTALL, STAGE_ZERO_TEST}) begin
         fail_action = ACTION_ROLLBACK_ZERO;
      end else begin
         fail_action = ACTION_KEEP;
      end
   end

   // Apply the event; anything refused leaves the state as it is.
   always_comb begin
      step.next     = cur;
      step.accepted = 1'b0;
      if (evt.command == CMD_RESET) begin
         step.next     = USC_STATE_RESET;
         step.accepted = 1'b1;
      end else if (evt.command == CMD_BEGIN) begin
         if (cur.stage == STAGE_IDLE) begin
            step.next.zero_changed   = evt.zero_image_changed;
            step.next.failure_action = ACTION_NONE;
            step.next.stage          = STAGE_DOWNLOAD;
            step.accepted            = 1'b1;
         end
      end else if (evt.command inside {[CMD_DOWNLOAD:CMD_PROMOTE]} &&
                   cur.stage == stage_type'(evt.command)) begin
         step.accepted = 1'b1;
         if (evt.success) begin
            case (cur.stage)
               STAGE_MAIN_TEST: begin
                  step.next.stage = cur.zero_changed ? STAGE_ZERO_XFER : STAGE_PROMOTE;
               end
               STAGE_PROMOTE: begin
                  step.next.stage = STAGE_COMPLETE;
               end
               default: begin
                  step.next.stage = stage_type'(cur.stage + 4'd1);
               end
            endcase
         end else begin
            step.next.failure_action = fail_action;
            step.next.stage          = STAGE_FAILED;
         end
      end
   end

endmodule

// File: rtl/update_sequence_controller_core.sv
// Top level of the firmware update sequence controller.
//
// Input channel req_*: one event transaction per handshake (command, success bit,
// secondary-image-changed flag). Result channel rsp_*: exactly one result
// transaction per event, in order, giving whether the event was taken and the
// stage, failure action and stored secondary flag after it.
// An accepted event waits in the input register; its result is then loaded
// into the result register and shows on rsp_*. One event per cycle while no
// result stalls on rsp_tready; the state update is a single decision on a few
// bits of registered state, taken as the event leaves the input register.
// The input register lets a new event be accepted while a result still waits:
// when rsp_tready is low the result holds, one more event is buffered, and
// req_tready then drops until the result is taken.
// Reset (synchronous, active high) empties both registers and returns the
// sequencer to idle with no failure action and the flag cleared. A reset
// command on the input channel does the same to the sequencer state and
// produces a result like any other event.
module update_sequence_controller_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [3:0] command, [4] success, [5] zero_image_changed
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [0] accepted, [4:1] stage, [6:5] failure_action,
                                   // [7] zero_flag
);
   import usc_pkg::*;

   logic           advance;
   logic           item_valid;
   usc_event_type  item;
   usc_step_type   step;
   usc_state_type  state_ff;
   usc_state_type  state_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   usc_result_type rsp_data_ff;
   usc_result_type rsp_data_in;
   logic           fire;

   // The result register can load when empty or being drained.
   assign advance = !rsp_valid_ff || rsp_tready;
   assign fire    = advance && item_valid;

   usc_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   usc_step u_step (
      .cur  (state_ff),
      .evt  (item),
      .step (step)
   );

   // Sequencer state moves only when an event transaction completes the step.
   assign state_in = fire ? step.next : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= USC_STATE_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

   // Result register valid flag.
   always_comb begin
      if (advance) begin
         rsp_valid_in = item_valid;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload: the acceptance flag and the state after the event.
   always_comb begin
      rsp_data_in.accepted       = step.accepted;
      rsp_data_in.stage          = step.next.stage;
      rsp_data_in.failure_action = step.next.failure_action;
      rsp_data_in.zero_flag      = step.next.zero_changed;
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: rtl/usc_checker.sv
// Port-level checker for the update sequence controller and its bind.
`include "update_sequence_controller_core_assert.svh"

module usc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);
   import usc_pkg::*;

   // No result transaction is offered right after reset.
   `USC_ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, !rsp_tvalid)

   // A stalled result holds its value.
   `USC_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_tvalid && !rsp_tready,
                    rsp_tvalid && $stable(rsp_tdata))

   // A recorded failure action is only seen in the failed stage.
   `USC_ASSERT_IMP(a_action_only_failed, clock, reset,
                   rsp_tvalid && rsp_tdata[6:5] != ACTION_NONE,
                   rsp_tdata[4:1] == STAGE_FAILED)

   // Idle means nothing else is remembered.
   `USC_ASSERT_IMP(a_idle_clean, clock, reset,
                   rsp_tvalid && rsp_tdata[4:1] == STAGE_IDLE,
                   rsp_tdata[7:5] == 3'd0)

   // Stage never leaves its defined range.
   `USC_ASSERT_IMP(a_stage_range, clock, reset, rsp_tvalid,
                   rsp_tdata[4:1] <= STAGE_FAILED)

endmodule

bind update_sequence_controller_core usc_checker u_usc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
